### sv/branch_top_two_select_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the branch top-two select unit
// Clocked on clk_i; rst_ni is the active-low reset.
// ----------------------------------------------------------------------------
`ifndef BRANCH_TOP_TWO_SELECT_UNIT_ASSERT_SVH
`define BRANCH_TOP_TWO_SELECT_UNIT_ASSERT_SVH

// Checked only outside reset.
`define BTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define BTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants, beat types and register codes of the top-two select unit.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int unsigned MaxRows  = 16;
  localparam int unsigned RowCntW  = $clog2(MaxRows + 1);
  localparam int unsigned RowIdxW  = $clog2(MaxRows);
  localparam int unsigned SupW     = 16;
  localparam int unsigned QualW    = 16;
  localparam int unsigned SumW     = SupW + 1;
  localparam int unsigned RatioW   = 8;
  localparam int unsigned NeedW    = SumW + RatioW;
  localparam int unsigned BranchW  = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [QualW-1:0]  ScoreLimitRst = QualW'(512);
  localparam logic [RatioW-1:0] RatioRst      = RatioW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    RegScoreLimit     = 1'b0,
    RegDominanceRatio = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SupW-1:0]  left_support;
    logic [SupW-1:0]  right_support;
    logic [QualW-1:0] left_quality;
    logic [QualW-1:0] right_quality;
    logic             final_row;
  } bts_in_t;

  typedef struct packed {
    logic [BranchW-1:0] chosen_branch;
    logic               chosen_ok;
  } bts_out_t;

  // Per-set tracking state; also the snapshot handed to the decision stage.
  typedef struct packed {
    logic [SumW-1:0]    best_sum;
    logic [RowIdxW-1:0] best_row;
    logic [QualW-1:0]   best_left_quality;
    logic [QualW-1:0]   best_right_quality;
    logic [SumW-1:0]    runner_sum;
    logic               runner_present;
  } bts_state_t;

endpackage

### sv/bts_acc.sv
// ----------------------------------------------------------------------------
// bts_acc
// Row tracker: keeps the largest and second-largest support sums of a set.
// ----------------------------------------------------------------------------
module bts_acc import bts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       row_fire_i,
  input  bts_in_t    row_i,
  output bts_state_t snap_o
);

  logic [RowCntW-1:0] row_q, row_d;
  bts_state_t         st_q, st_d, nx;
  logic [SumW-1:0]    sum;
  logic               in_range;
  logic               first_row;

  assign sum       = SumW'(row_i.left_support) + SumW'(row_i.right_support);
  assign in_range  = row_q < RowCntW'(MaxRows);
  assign first_row = (row_q == '0);

  always_comb begin
    nx    = st_q;
    row_d = row_q;
    if (in_range) begin
      if (first_row || (sum > st_q.best_sum)) begin
        if (!first_row) begin
          nx.runner_sum     = st_q.best_sum;
          nx.runner_present = 1'b1;
        end
        nx.best_sum           = sum;
        nx.best_row           = row_q[RowIdxW-1:0];
        nx.best_left_quality  = row_i.left_quality;
        nx.best_right_quality = row_i.right_quality;
      end else if (!st_q.runner_present || (sum > st_q.runner_sum)) begin
        nx.runner_sum     = sum;
        nx.runner_present = 1'b1;
      end
      row_d = row_q + RowCntW'(1);
    end
  end

  // Final row closes the set: hand off the updated state, start clean.
  always_comb begin
    st_d = st_q;
    if (row_fire_i) begin
      if (row_i.final_row) begin
        st_d  = '0;
      end else begin
        st_d  = nx;
      end
    end
  end

  assign snap_o = nx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      st_q  <= '0;
    end else if (row_fire_i) begin
      row_q <= row_i.final_row ? '0 : row_d;
      st_q  <= st_d;
    end
  end

endmodule

### sv/bts_decide.sv
// ----------------------------------------------------------------------------
// bts_decide
// Holds a closed set's snapshot, applies the dominance test, registers result.
// ----------------------------------------------------------------------------
module bts_decide import bts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              snap_vld_i,
  input  bts_state_t        snap_i,
  input  logic [QualW-1:0]  score_limit_i,
  input  logic [RatioW-1:0] ratio_i,
  output logic              snap_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bts_out_t          out_data_o
);

  logic        snap_vld_q;
  bts_state_t  snap_q;
  logic        out_vld_q;
  bts_out_t    out_q, out_d;
  logic        out_free;
  logic        snap_move;
  logic [NeedW-1:0] need;
  logic        chosen;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign snap_move   = snap_vld_q && out_free;
  assign snap_free_o = !snap_vld_q || out_free;

  assign need = NeedW'(ratio_i) * NeedW'(snap_q.runner_sum);

  always_comb begin
    chosen = 1'b0;
    if (snap_q.runner_present) begin
      if (snap_q.runner_sum == '0) begin
        chosen = (snap_q.best_sum != '0);
      end else begin
        chosen = (NeedW'(snap_q.best_sum) >= need) &&
                 (snap_q.best_left_quality < score_limit_i) &&
                 (snap_q.best_right_quality < score_limit_i);
      end
    end
    out_d.chosen_ok     = chosen;
    out_d.chosen_branch = chosen ? BranchW'(snap_q.best_row) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (snap_free_o) begin
        snap_vld_q <= snap_vld_i;
      end
      if (out_free) begin
        out_vld_q <= snap_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_free_o && snap_vld_i) begin
      snap_q <= snap_i;
    end
    if (snap_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### sv/branch_top_two_select_unit.sv
// Path: a final row beat passes the input register, the snapshot register
//   and the result register, in that order, before out_valid_o shows it.
// Throughput: one row per cycle; the only stall comes from a final row
//   meeting a full snapshot register while the result beat is held.
// Reset: asynchronous, active low; clears the row tracking and all valid
//   flags, sets score_limit to 512 (2.0 in Q8.8) and dominance_ratio to 2.
// ----------------------------------------------------------------------------
// branch_top_two_select_unit
// Picks the dominant branch of a set of rows by support sum and scores.
// ----------------------------------------------------------------------------
module branch_top_two_select_unit import bts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bts_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bts_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic              in_vld_q;
  bts_in_t           in_q;
  logic              in_free;
  logic              row_fire;
  logic              snap_free;
  bts_state_t        snap;
  logic [QualW-1:0]  score_limit_q;
  logic [RatioW-1:0] ratio_q;

  // A final row needs room in the snapshot register; other rows never wait.
  assign row_fire   = in_vld_q && (!in_q.final_row || snap_free);
  assign in_free    = !in_vld_q || row_fire;
  assign in_stall_o = !in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_free) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_limit_q <= ScoreLimitRst;
      ratio_q       <= RatioRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegScoreLimit:     score_limit_q <= cfg_data_i[QualW-1:0];
        RegDominanceRatio: ratio_q       <= cfg_data_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  bts_acc u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .row_fire_i (row_fire),
    .row_i      (in_q),
    .snap_o     (snap)
  );

  bts_decide u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .snap_vld_i    (row_fire && in_q.final_row),
    .snap_i        (snap),
    .score_limit_i (score_limit_q),
    .ratio_i       (ratio_q),
    .snap_free_o   (snap_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

### sv/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks of the top-two select unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "branch_top_two_select_unit_assert.svh"

module bts_checker import bts_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input bts_out_t out_data_o
);

  `BTS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result beat during reset")

  `BTS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")

  `BTS_ASSERT(a_no_choice_zero, out_valid_o && !out_data_o.chosen_ok |-> out_data_o.chosen_branch == '0, "branch index set without a choice")

  // Input only backs up when the result side is full and held.
  `BTS_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free result side")

endmodule

bind branch_top_two_select_unit bts_checker u_bts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
